// File: design/idmya_pkg.sv
// ----------------------------------------------------------------------------
// idmya_pkg
// shared constants, register codes and types of the car-following block
// ----------------------------------------------------------------------------
package idmya_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DEN_MIN   = 1 << (FRAC_BITS - 1);

  localparam int GAIN_W = 16;
  localparam int POS_W  = 24;
  localparam int SPD_W  = 16;
  localparam int ACC_W  = 14;
  localparam int OUT_W  = 16;

  // products and sums along the datapath
  localparam int DV_W   = SPD_W + 1;
  localparam int TV_W   = SPD_W + 2;
  localparam int GAP_W  = POS_W + 1;
  localparam int M1_W   = GAIN_W + 1 + DV_W;
  localparam int M2_W   = GAIN_W + 1 + SPD_W;
  localparam int M3_W   = GAIN_W + 1 + TV_W;
  localparam int P_W    = M1_W - FRAC_BITS;
  localparam int KP_W   = P_W + 1;
  localparam int M4_W   = KP_W + SPD_W;
  localparam int M5_W   = M2_W + ACC_W;
  localparam int DR_W   = M3_W - FRAC_BITS + 1;
  localparam int DEN_W  = DR_W;
  localparam int IDL_W  = M4_W - FRAC_BITS + 1;
  localparam int GD_W   = IDL_W + 1;
  localparam int T5_W   = M5_W - FRAC_BITS;
  localparam int M6_W   = GAIN_W + 1 + GD_W;
  localparam int NUM_W  = M6_W + 3;
  localparam int DIV_BITS = OUT_W;
  localparam int REM_W  = DEN_W + DIV_BITS;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic [2:0] {
    REG_ALPHA    = 3'd0,
    REG_BETA     = 3'd1,
    REG_HEADWAY  = 3'd2,
    REG_STANDGAP = 3'd3,
    REG_GATEMODE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic valid;
    logic neg;
    logic ovf;
  } div_ctl_t;

endpackage

// File: design/idmya_div.sv
// ----------------------------------------------------------------------------
// idmya_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module idmya_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  idmya_pkg::div_ctl_t           in_ctl,
  input  logic [idmya_pkg::REM_W-1:0]   in_rem,
  input  logic [idmya_pkg::DEN_W-1:0]   in_den,
  output idmya_pkg::div_ctl_t           out_ctl,
  output logic [idmya_pkg::DIV_BITS-1:0] out_quo
);
  import idmya_pkg::*;

  div_ctl_t              ctl_r [DIV_BITS];
  logic [REM_W-1:0]      rem_r [DIV_BITS];
  logic [DEN_W-1:0]      den_r [DIV_BITS];
  logic [DIV_BITS-1:0]   quo_r [DIV_BITS];

  for (genvar g = 0; g < DIV_BITS; g++) begin : g_stage
    localparam int B = DIV_BITS - 1 - g;
    div_ctl_t            ctl_in;
    logic [REM_W-1:0]    rem_in;
    logic [DEN_W-1:0]    den_in;
    logic [DIV_BITS-1:0] quo_in;
    logic [REM_W-1:0]    dsh;
    logic                take;

    if (g == 0) begin : g_first
      assign ctl_in = in_ctl;
      assign rem_in = in_rem;
      assign den_in = in_den;
      assign quo_in = '0;
    end else begin : g_next
      assign ctl_in = ctl_r[g-1];
      assign rem_in = rem_r[g-1];
      assign den_in = den_r[g-1];
      assign quo_in = quo_r[g-1];
    end

    assign dsh  = REM_W'(den_in) << B;
    assign take = rem_in >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[g] <= '0;
      end else if (en) begin
        ctl_r[g] <= ctl_in;
      end
      if (en) begin
        rem_r[g] <= take ? rem_in - dsh : rem_in;
        den_r[g] <= den_in;
        quo_r[g] <= quo_in | (DIV_BITS'(take) << B);
      end
    end
  end

  assign out_ctl = ctl_r[DIV_BITS-1];
  assign out_quo = quo_r[DIV_BITS-1];

  // apart from items flagged as overflow, the divider never sees a remainder beyond its quotient range
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r[0].valid && !ctl_r[0].ovf |-> rem_r[0] < (REM_W'(den_r[0]) << (DIV_BITS - 1)))
    else $error("divider remainder out of range");
  a_den_floor: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r[0].valid |-> den_r[0] >= DEN_W'(DEN_MIN))
    else $error("divider denominator below floor");
endmodule

// File: design/idm_yield_acceleration.sv
// ----------------------------------------------------------------------------
// idm_yield_acceleration
// car-following acceleration: gaps, gains and a pipelined divide
// ----------------------------------------------------------------------------
// stages: 7 datapath stages, then 16 divider stages, then 1 output register
// throughput: one item per cycle; the whole pipeline holds when the output
//   register is full and not taken
// reset: rst_n synchronous, clears valid bits and loads register defaults
module idm_yield_acceleration (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [idmya_pkg::POS_W-1:0]   in_ego_position,
  input  logic signed [idmya_pkg::POS_W-1:0]   in_agent_position,
  input  logic signed [idmya_pkg::SPD_W-1:0]   in_ego_speed,
  input  logic signed [idmya_pkg::SPD_W-1:0]   in_agent_speed,
  input  logic signed [idmya_pkg::ACC_W-1:0]   in_agent_accel,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [idmya_pkg::OUT_W-1:0]   out_accel_out,
  output logic                                 out_saturated,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [idmya_pkg::APB_AW-1:0]         cfg_paddr,
  input  logic [idmya_pkg::APB_DW-1:0]         cfg_pwdata,
  output logic [idmya_pkg::APB_DW-1:0]         cfg_prdata,
  output logic                                 cfg_pready
);
  import idmya_pkg::*;

  logic [GAIN_W-1:0] alpha_r, beta_r, k0_r, d0_r;
  logic              gate_r;
  reg_idx_t          widx;
  logic              wr;

  assign cfg_pready = 1'b1;
  assign wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign widx = reg_idx_t'(cfg_paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= '0;
      beta_r  <= GAIN_W'(256);
      k0_r    <= GAIN_W'(256);
      d0_r    <= GAIN_W'(1280);
      gate_r  <= 1'b1;
    end else if (wr) begin
      unique case (widx)
        REG_ALPHA:    alpha_r <= cfg_pwdata[GAIN_W-1:0];
        REG_BETA:     beta_r  <= cfg_pwdata[GAIN_W-1:0];
        REG_HEADWAY:  k0_r    <= cfg_pwdata[GAIN_W-1:0];
        REG_STANDGAP: d0_r    <= cfg_pwdata[GAIN_W-1:0];
        REG_GATEMODE: gate_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_ALPHA:    cfg_prdata = APB_DW'(alpha_r);
      REG_BETA:     cfg_prdata = APB_DW'(beta_r);
      REG_HEADWAY:  cfg_prdata = APB_DW'(k0_r);
      REG_STANDGAP: cfg_prdata = APB_DW'(d0_r);
      REG_GATEMODE: cfg_prdata = APB_DW'(gate_r);
      default:      cfg_prdata = '0;
    endcase
  end

  logic signed [GAIN_W:0] k0_s, d0_s, beta_s;
  assign k0_s   = $signed({1'b0, k0_r});
  assign d0_s   = $signed({1'b0, d0_r});
  assign beta_s = $signed({1'b0, beta_r});

  logic out_valid_r;
  logic en;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // stage 1: gated gain, speed differences, clamped gap
  logic [GAIN_W-1:0]        a_eff;
  logic signed [DV_W-1:0]   dv;
  logic signed [TV_W-1:0]   tv;
  logic signed [GAP_W-1:0]  gap_raw;
  assign a_eff   = (gate_r && (in_ego_speed < in_agent_speed)) ? '0 : alpha_r;
  assign dv      = DV_W'(in_ego_speed) - DV_W'(in_agent_speed);
  assign tv      = TV_W'(in_ego_speed) + TV_W'(in_ego_speed) - TV_W'(in_agent_speed);
  assign gap_raw = GAP_W'(in_agent_position) - GAP_W'(in_ego_position);

  logic                     s1_v_r;
  logic signed [GAIN_W:0]   s1_a_r;
  logic signed [DV_W-1:0]   s1_dv_r;
  logic signed [TV_W-1:0]   s1_tv_r;
  logic signed [GAP_W-1:0]  s1_gap_r;
  logic signed [SPD_W-1:0]  s1_ev_r;
  logic signed [ACC_W-1:0]  s1_aa_r;

  // stage 2: gain products
  logic                     s2_v_r;
  logic signed [M1_W-1:0]   s2_m1_r;
  logic signed [M2_W-1:0]   s2_m2_r;
  logic signed [M3_W-1:0]   s2_m3_r;
  logic signed [DV_W-1:0]   s2_dv_r;
  logic signed [GAP_W-1:0]  s2_gap_r;
  logic signed [SPD_W-1:0]  s2_ev_r;
  logic signed [ACC_W-1:0]  s2_aa_r;

  // stage 3: headway product, accel product, denominator
  logic signed [P_W-1:0]    p;
  logic signed [KP_W-1:0]   kp;
  logic signed [DR_W-1:0]   dr;
  assign p  = P_W'(s2_m1_r >>> FRAC_BITS);
  assign kp = KP_W'(k0_s) + KP_W'(p);
  assign dr = DR_W'(k0_s) + DR_W'(s2_m3_r >>> FRAC_BITS);

  logic                     s3_v_r;
  logic signed [M4_W-1:0]   s3_m4_r;
  logic signed [M5_W-1:0]   s3_m5_r;
  logic [DEN_W-1:0]         s3_den_r;
  logic signed [DV_W-1:0]   s3_dv_r;
  logic signed [GAP_W-1:0]  s3_gap_r;

  // stage 4: ideal gap and gap error
  logic signed [IDL_W-1:0]  ideal;
  assign ideal = IDL_W'(d0_s) + IDL_W'(s3_m4_r >>> FRAC_BITS);

  logic                     s4_v_r;
  logic signed [GD_W-1:0]   s4_gd_r;
  logic signed [T5_W-1:0]   s4_t5_r;
  logic [DEN_W-1:0]         s4_den_r;
  logic signed [DV_W-1:0]   s4_dv_r;

  // stage 5: gap error gain
  logic                     s5_v_r;
  logic signed [M6_W-1:0]   s5_m6_r;
  logic signed [T5_W-1:0]   s5_t5_r;
  logic [DEN_W-1:0]         s5_den_r;
  logic signed [DV_W-1:0]   s5_dv_r;

  // stage 6: numerator
  logic signed [NUM_W-1:0]  num;
  assign num = NUM_W'(s5_m6_r) + NUM_W'(s5_t5_r) - (NUM_W'(s5_dv_r) <<< FRAC_BITS);

  logic                     s6_v_r;
  logic signed [NUM_W-1:0]  s6_num_r;
  logic [DEN_W-1:0]         s6_den_r;

  // stage 7: magnitude and range check
  logic [NUM_W-1:0]         absn;
  assign absn = s6_num_r[NUM_W-1] ? NUM_W'(-s6_num_r) : NUM_W'(s6_num_r);

  div_ctl_t                 s7_ctl_r;
  logic [REM_W-1:0]         s7_rem_r;
  logic [DEN_W-1:0]         s7_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
      s4_v_r   <= 1'b0;
      s5_v_r   <= 1'b0;
      s6_v_r   <= 1'b0;
      s7_ctl_r <= '0;
    end else if (en) begin
      s1_v_r         <= in_valid;
      s2_v_r         <= s1_v_r;
      s3_v_r         <= s2_v_r;
      s4_v_r         <= s3_v_r;
      s5_v_r         <= s4_v_r;
      s6_v_r         <= s5_v_r;
      s7_ctl_r.valid <= s6_v_r;
      s7_ctl_r.neg   <= s6_num_r[NUM_W-1];
      s7_ctl_r.ovf   <= absn >= (NUM_W'(s6_den_r) << DIV_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r   <= $signed({1'b0, a_eff});
      s1_dv_r  <= dv;
      s1_tv_r  <= tv;
      s1_gap_r <= gap_raw[GAP_W-1] ? '0 : gap_raw;
      s1_ev_r  <= in_ego_speed;
      s1_aa_r  <= in_agent_accel;

      s2_m1_r  <= M1_W'(s1_a_r) * M1_W'(s1_dv_r);
      s2_m2_r  <= M2_W'(s1_a_r) * M2_W'(s1_ev_r);
      s2_m3_r  <= M3_W'(s1_a_r) * M3_W'(s1_tv_r);
      s2_dv_r  <= s1_dv_r;
      s2_gap_r <= s1_gap_r;
      s2_ev_r  <= s1_ev_r;
      s2_aa_r  <= s1_aa_r;

      s3_m4_r  <= M4_W'(kp) * M4_W'(s2_ev_r);
      s3_m5_r  <= M5_W'(s2_m2_r) * M5_W'(s2_aa_r);
      s3_den_r <= (dr < $signed(DR_W'(DEN_MIN))) ? DEN_W'(DEN_MIN) : DEN_W'(dr);
      s3_dv_r  <= s2_dv_r;
      s3_gap_r <= s2_gap_r;

      s4_gd_r  <= GD_W'(s3_gap_r) - GD_W'(ideal);
      s4_t5_r  <= T5_W'(s3_m5_r >>> FRAC_BITS);
      s4_den_r <= s3_den_r;
      s4_dv_r  <= s3_dv_r;

      s5_m6_r  <= M6_W'(beta_s) * M6_W'(s4_gd_r);
      s5_t5_r  <= s4_t5_r;
      s5_den_r <= s4_den_r;
      s5_dv_r  <= s4_dv_r;

      s6_num_r <= num;
      s6_den_r <= s5_den_r;

      s7_rem_r <= absn[REM_W-1:0];
      s7_den_r <= s6_den_r;
    end
  end

  div_ctl_t             dq_ctl;
  logic [DIV_BITS-1:0]  dq_quo;

  idmya_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_ctl  (s7_ctl_r),
    .in_rem  (s7_rem_r),
    .in_den  (s7_den_r),
    .out_ctl (dq_ctl),
    .out_quo (dq_quo)
  );

  // sign and clip
  logic signed [OUT_W-1:0] q_fin;
  logic                    sat_fin;
  always_comb begin
    if (dq_ctl.ovf) begin
      sat_fin = 1'b1;
      q_fin   = dq_ctl.neg ? $signed({1'b1, {(OUT_W-1){1'b0}}})
                           : $signed({1'b0, {(OUT_W-1){1'b1}}});
    end else if (dq_ctl.neg) begin
      sat_fin = dq_quo > {1'b1, {(OUT_W-1){1'b0}}};
      q_fin   = sat_fin ? $signed({1'b1, {(OUT_W-1){1'b0}}})
                        : $signed(OUT_W'((OUT_W + 1)'(0) - {1'b0, dq_quo}));
    end else begin
      sat_fin = dq_quo[OUT_W-1];
      q_fin   = sat_fin ? $signed({1'b0, {(OUT_W-1){1'b1}}}) : $signed(dq_quo);
    end
  end

  logic signed [OUT_W-1:0] accel_r;
  logic                    sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dq_ctl.valid;
    end
    if (en) begin
      accel_r <= q_fin;
      sat_r   <= sat_fin;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_accel_out = accel_r;
  assign out_saturated = sat_r;

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_accel_out == 16'sh7fff || out_accel_out == 16'sh8000))
    else $error("saturated item not at a bound");
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    en && dq_ctl.valid && dq_ctl.ovf |=> out_valid && out_saturated)
    else $error("divider overflow not flagged");
  a_den_floor: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |-> s4_den_r >= DEN_W'(DEN_MIN))
    else $error("denominator below floor");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !s1_v_r)
    else $error("valid after reset");
endmodule
